// ----- rtl/fct_pkg.sv -----
package fct_pkg;

	localparam int ENTRIES     = 1024;
	localparam int PAIRS       = (ENTRIES + 1) / 2;
	localparam int TABLE_BYTES = PAIRS * 3;

	localparam int PAIR_W  = $clog2(PAIRS);
	localparam int END_W   = $clog2(ENTRIES + 1);
	localparam int IDX_W   = 10;
	localparam int LINK_W  = 12;
	localparam int OFF_W   = 11;
	localparam int OFFX_W  = OFF_W + 1;
	localparam int BYTE_W  = 8;
	localparam int CNT_W   = 10;
	localparam int FUNC_W  = 3;
	localparam int ST_W    = 2;
	localparam int WORD_W  = 2 * LINK_W;

	localparam int RECIP3    = 683;
	localparam int RECIP3_SH = 11;
	localparam int PROD_W    = OFF_W + 10;

	localparam logic [FUNC_W-1:0] F_READ   = 3'd0;
	localparam logic [FUNC_W-1:0] F_STORE  = 3'd1;
	localparam logic [FUNC_W-1:0] F_REMOVE = 3'd2;
	localparam logic [FUNC_W-1:0] F_FIRST  = 3'd3;
	localparam logic [FUNC_W-1:0] F_SECOND = 3'd4;
	localparam logic [FUNC_W-1:0] F_COUNT  = 3'd5;
	localparam logic [FUNC_W-1:0] F_WRBYTE = 3'd6;
	localparam logic [FUNC_W-1:0] F_RDBYTE = 3'd7;

	localparam logic [ST_W-1:0] ST_OK     = 2'd0;
	localparam logic [ST_W-1:0] ST_NOFREE = 2'd1;
	localparam logic [ST_W-1:0] ST_RANGE  = 2'd2;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              err;
		logic [PAIR_W-1:0] pair;
		logic              half;
		logic [1:0]        lane;
		logic [LINK_W-1:0] link;
		logic [BYTE_W-1:0] bdata;
	} cmd_t;

	typedef struct packed {
		logic              valid;
		logic [LINK_W-1:0] value;
		logic [BYTE_W-1:0] byte_out;
		logic [ST_W-1:0]   status;
	} res_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

// ----- rtl/fat12_cluster_table.sv -----
// A transfer passes the staging register and queue; read, store, remove and byte access then
// pass the access state; an index or offset out of range or an empty-range scan is answered
// from idle. A scan reads one pair per cycle, covers at most ceil(usable_entry_count/2) pairs,
// 511, and for first and second stops at a hit. The back end pops only while idle; a staging
// register and a two-entry queue hold transfers, and busy is high while both are full.
// Reset clears control and usable_entry_count; table undefined until written; receiver cannot stall.
module fat12_cluster_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [fct_pkg::FUNC_W-1:0]  func,
	input  logic [fct_pkg::IDX_W-1:0]   entry_index,
	input  logic [fct_pkg::LINK_W-1:0]  link_value,
	input  logic [fct_pkg::OFF_W-1:0]   byte_offset,
	input  logic [fct_pkg::BYTE_W-1:0]  byte_data,
	input  logic                        cfg_wr_en,
	input  logic [fct_pkg::CNT_W-1:0]   cfg_wr_data,
	output logic                        done,
	output logic [fct_pkg::LINK_W-1:0]  value,
	output logic [fct_pkg::BYTE_W-1:0]  byte_out,
	output logic [fct_pkg::ST_W-1:0]    status
);

	logic [fct_pkg::CNT_W-1:0] usable_cnt_q;
	fct_pkg::qstat_t           qstat;
	fct_pkg::cmd_t             push_cmd;
	fct_pkg::cmd_t             head;
	fct_pkg::res_t             res;
	logic                      push;
	logic                      pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			usable_cnt_q <= '0;
		end else if (cfg_wr_en) begin
			usable_cnt_q <= cfg_wr_data;
		end
	end

	fct_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.func        (func),
		.entry_index (entry_index),
		.link_value  (link_value),
		.byte_offset (byte_offset),
		.byte_data   (byte_data),
		.qstat       (qstat),
		.busy        (busy),
		.push        (push),
		.push_cmd    (push_cmd)
	);

	fct_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	fct_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.usable_cnt (usable_cnt_q),
		.qstat      (qstat),
		.head       (head),
		.pop        (pop),
		.res        (res)
	);

	assign done     = res.valid;
	assign value    = res.value;
	assign byte_out = res.byte_out;
	assign status   = res.status;

	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == fct_pkg::ST_RANGE) |-> (value == '0) && (byte_out == '0))
		else $error("range error carries nonzero payload");

	a_nofree_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == fct_pkg::ST_NOFREE) |-> (value == '0) && (byte_out == '0))
		else $error("no-free result carries nonzero payload");

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a preceding transfer");

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("push into a full queue");

endmodule

// ----- rtl/fct_front.sv -----
module fct_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [fct_pkg::FUNC_W-1:0]  func,
	input  logic [fct_pkg::IDX_W-1:0]   entry_index,
	input  logic [fct_pkg::LINK_W-1:0]  link_value,
	input  logic [fct_pkg::OFF_W-1:0]   byte_offset,
	input  logic [fct_pkg::BYTE_W-1:0]  byte_data,
	input  fct_pkg::qstat_t             qstat,
	output logic                        busy,
	output logic                        push,
	output fct_pkg::cmd_t               push_cmd
);

	logic                        vld_s1;
	logic [fct_pkg::FUNC_W-1:0]  func_s1;
	logic [fct_pkg::IDX_W-1:0]   idx_s1;
	logic [fct_pkg::LINK_W-1:0]  link_s1;
	logic [fct_pkg::OFF_W-1:0]   off_s1;
	logic [fct_pkg::BYTE_W-1:0]  bdata_s1;
	logic                        accept;
	logic [fct_pkg::PROD_W-1:0]  prod;
	logic [fct_pkg::OFF_W-1:0]   quot;
	logic [fct_pkg::OFF_W-1:0]   rem;
	logic                        is_byte_op;

	assign busy   = vld_s1 & qstat.full;
	assign accept = start & ~busy;
	assign push   = vld_s1 & ~qstat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1  <= func;
			idx_s1   <= entry_index;
			link_s1  <= link_value;
			off_s1   <= byte_offset;
			bdata_s1 <= byte_data;
		end
	end

	// divide the byte offset by three through a reciprocal
	assign prod = fct_pkg::PROD_W'(off_s1) * fct_pkg::PROD_W'(fct_pkg::RECIP3);
	assign quot = fct_pkg::OFF_W'(prod >> fct_pkg::RECIP3_SH);
	assign rem  = off_s1 - ((quot << 1) + quot);

	assign is_byte_op = (func_s1 == fct_pkg::F_WRBYTE) || (func_s1 == fct_pkg::F_RDBYTE);

	always_comb begin
		push_cmd.func  = func_s1;
		push_cmd.link  = link_s1;
		push_cmd.bdata = bdata_s1;
		push_cmd.half  = idx_s1[0];
		push_cmd.lane  = rem[1:0];
		push_cmd.err   = 1'b0;
		push_cmd.pair  = fct_pkg::PAIR_W'(idx_s1 >> 1);
		case (func_s1)
			fct_pkg::F_READ, fct_pkg::F_STORE, fct_pkg::F_REMOVE: begin
				push_cmd.err = fct_pkg::END_W'(idx_s1) >= fct_pkg::END_W'(fct_pkg::ENTRIES);
			end
			fct_pkg::F_WRBYTE, fct_pkg::F_RDBYTE: begin
				push_cmd.err  = fct_pkg::OFFX_W'(off_s1) >= fct_pkg::OFFX_W'(fct_pkg::TABLE_BYTES);
				push_cmd.pair = fct_pkg::PAIR_W'(quot);
			end
			default: begin
				push_cmd.err = 1'b0;
			end
		endcase
		if (!is_byte_op) begin
			push_cmd.lane = 2'd0;
		end
	end

endmodule

// ----- rtl/fct_queue.sv -----
module fct_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  fct_pkg::cmd_t   push_cmd,
	input  logic            pop,
	output fct_pkg::cmd_t   head,
	output fct_pkg::qstat_t qstat
);

	fct_pkg::cmd_t slot_q [2];
	logic          wp_q;
	logic          rp_q;
	logic [1:0]    cnt_q;

	assign head        = slot_q[rp_q];
	assign qstat.full  = cnt_q == 2'd2;
	assign qstat.empty = cnt_q == 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= push_cmd;
		end
	end

endmodule

// ----- rtl/fct_back.sv -----
module fct_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [fct_pkg::CNT_W-1:0]  usable_cnt,
	input  fct_pkg::qstat_t            qstat,
	input  fct_pkg::cmd_t              head,
	output logic                       pop,
	output fct_pkg::res_t              res
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_ACC  = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;

	localparam int LW = fct_pkg::LINK_W;
	localparam int BW = fct_pkg::BYTE_W;
	localparam int EW = fct_pkg::END_W;
	localparam int PW = fct_pkg::PAIR_W;

	logic [fct_pkg::WORD_W-1:0] mem [fct_pkg::PAIRS];
	logic [fct_pkg::WORD_W-1:0] rd_data_q;

	logic [1:0]          state_q;
	fct_pkg::cmd_t       cur_q;
	logic [EW-1:0]       end_q;
	logic [PW:0]         ip_q;
	logic                rv_s1;
	logic [PW-1:0]       ep_s1;
	logic [LW-1:0]       cnt_q;
	logic                found_q;
	fct_pkg::res_t       res_q;

	logic                re;
	logic [PW-1:0]       ra;
	logic                we;
	logic [fct_pkg::WORD_W-1:0] wd;
	logic                issue;
	logic                is_scan;
	logic [EW:0]         sum_end;
	logic [EW-1:0]       new_end;
	logic [LW-1:0]       lo;
	logic [LW-1:0]       hi;
	logic [LW-1:0]       old;
	logic [EW-1:0]       e0;
	logic [EW-1:0]       e1;
	logic                f0;
	logic                f1;
	logic                hit;
	logic [EW-1:0]       hit_idx;
	logic                last;
	logic                finish;
	logic [LW-1:0]       cnt_next;
	fct_pkg::res_t       res_d;

	assign res = res_q;

	assign is_scan = (head.func == fct_pkg::F_FIRST) || (head.func == fct_pkg::F_SECOND)
		|| (head.func == fct_pkg::F_COUNT);
	assign sum_end = (EW + 1)'(usable_cnt) + (EW + 1)'(2);
	assign new_end = (sum_end > (EW + 1)'(fct_pkg::ENTRIES)) ? EW'(fct_pkg::ENTRIES)
		: EW'(sum_end);

	assign pop = (state_q == S_IDLE) && !qstat.empty;

	assign lo  = rd_data_q[LW-1:0];
	assign hi  = rd_data_q[2*LW-1:LW];
	assign old = cur_q.half ? hi : lo;

	assign e0   = EW'({ep_s1, 1'b0});
	assign e1   = e0 + EW'(1);
	assign f0   = (lo == '0) && (e0 < end_q);
	assign f1   = (hi == '0) && (e1 < end_q);
	assign last = ((EW + 1)'(e0) + (EW + 1)'(2)) >= (EW + 1)'(end_q);
	assign cnt_next = cnt_q + LW'(f0) + LW'(f1);

	always_comb begin
		if ((cur_q.func == fct_pkg::F_FIRST) || found_q) begin
			hit     = f0 | f1;
			hit_idx = f0 ? e0 : e1;
		end else begin
			hit     = f0 & f1;
			hit_idx = e1;
		end
	end

	assign finish = (state_q == S_SCAN) && rv_s1
		&& ((cur_q.func == fct_pkg::F_COUNT) ? last : (hit || last));
	assign issue = (state_q == S_SCAN) && !finish && (EW'({ip_q, 1'b0}) < end_q);

	assign re = pop || issue;
	assign ra = pop ? head.pair : ip_q[PW-1:0];

	always_comb begin
		we = 1'b0;
		wd = rd_data_q;
		res_d = '0;
		res_d.status = fct_pkg::ST_OK;
		case (state_q)
			S_IDLE: begin
				if (pop && head.err) begin
					res_d.valid  = 1'b1;
					res_d.status = fct_pkg::ST_RANGE;
				end else if (pop && is_scan && (new_end <= EW'(2))) begin
					res_d.valid = 1'b1;
					if (head.func != fct_pkg::F_COUNT) begin
						res_d.status = fct_pkg::ST_NOFREE;
					end
				end
			end
			S_ACC: begin
				res_d.valid = 1'b1;
				case (cur_q.func)
					fct_pkg::F_READ: begin
						res_d.value = old;
					end
					fct_pkg::F_STORE: begin
						we = 1'b1;
						if (cur_q.half) begin
							wd = {cur_q.link, lo};
						end else begin
							wd = {hi, cur_q.link};
						end
					end
					fct_pkg::F_REMOVE: begin
						we = 1'b1;
						res_d.value = old;
						if (cur_q.half) begin
							wd = {{LW{1'b0}}, lo};
						end else begin
							wd = {hi, {LW{1'b0}}};
						end
					end
					fct_pkg::F_WRBYTE: begin
						we = 1'b1;
						case (cur_q.lane)
							2'd0: wd = {rd_data_q[3*BW-1:BW], cur_q.bdata};
							2'd1: wd = {rd_data_q[3*BW-1:2*BW], cur_q.bdata,
								rd_data_q[BW-1:0]};
							default: wd = {cur_q.bdata, rd_data_q[2*BW-1:0]};
						endcase
					end
					default: begin
						case (cur_q.lane)
							2'd0: res_d.byte_out = rd_data_q[BW-1:0];
							2'd1: res_d.byte_out = rd_data_q[2*BW-1:BW];
							default: res_d.byte_out = rd_data_q[3*BW-1:2*BW];
						endcase
					end
				endcase
			end
			S_SCAN: begin
				if (finish) begin
					res_d.valid = 1'b1;
					if (cur_q.func == fct_pkg::F_COUNT) begin
						res_d.value = cnt_next;
					end else if (hit) begin
						res_d.value = LW'(hit_idx);
					end else begin
						res_d.status = fct_pkg::ST_NOFREE;
					end
				end
			end
			default: begin
				res_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[cur_q.pair] <= wd;
		end
		if (re) begin
			rd_data_q <= mem[ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rv_s1   <= 1'b0;
			res_q   <= '0;
			found_q <= 1'b0;
			cnt_q   <= '0;
			ip_q    <= '0;
			end_q   <= '0;
		end else begin
			res_q <= res_d;
			rv_s1 <= issue;
			case (state_q)
				S_IDLE: begin
					if (pop && !head.err) begin
						if (!is_scan) begin
							state_q <= S_ACC;
						end else if (new_end > EW'(2)) begin
							state_q <= S_SCAN;
						end
					end
					found_q <= 1'b0;
					cnt_q   <= '0;
					ip_q    <= (PW + 1)'(1);
					end_q   <= new_end;
				end
				S_ACC: begin
					state_q <= S_IDLE;
				end
				S_SCAN: begin
					if (issue) begin
						ip_q <= ip_q + (PW + 1)'(1);
					end
					if (rv_s1) begin
						cnt_q   <= cnt_next;
						found_q <= found_q | f0 | f1;
					end
					if (finish) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (issue) begin
			ep_s1 <= ip_q[PW-1:0];
		end
	end

endmodule

// ----- bench/fct_checker.sv -----
`timescale 1ns / 1ps

module fct_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  logic [fct_pkg::FUNC_W-1:0]  func,
	input  logic [fct_pkg::IDX_W-1:0]   entry_index,
	input  logic [fct_pkg::LINK_W-1:0]  link_value,
	input  logic [fct_pkg::OFF_W-1:0]   byte_offset,
	input  logic [fct_pkg::BYTE_W-1:0]  byte_data,
	input  logic                        cfg_wr_en,
	input  logic [fct_pkg::CNT_W-1:0]   cfg_wr_data,
	input  logic                        done,
	input  logic [fct_pkg::LINK_W-1:0]  value,
	input  logic [fct_pkg::BYTE_W-1:0]  byte_out,
	input  logic [fct_pkg::ST_W-1:0]    status,
	output int                          fail_count,
	output int                          outstanding
);

	typedef struct packed {
		logic [fct_pkg::LINK_W-1:0] value;
		logic [fct_pkg::BYTE_W-1:0] byte_out;
		logic [fct_pkg::ST_W-1:0]   status;
	} outcome_t;

	logic [fct_pkg::WORD_W-1:0] pair_words [fct_pkg::PAIRS];
	logic [fct_pkg::CNT_W-1:0]  scan_len;
	outcome_t                   pending_results [$];

	initial begin
		foreach (pair_words[p])
			pair_words[p] = '0;
		scan_len = '0;
		fail_count = 0;
		outstanding = 0;
	end

	function automatic logic [fct_pkg::LINK_W-1:0] entry_link(input int e);
		logic [fct_pkg::WORD_W-1:0] w;
		w = pair_words[e >> 1];
		return e[0] ? w[fct_pkg::WORD_W-1:fct_pkg::LINK_W] : w[fct_pkg::LINK_W-1:0];
	endfunction

	task automatic set_link(input int e, input logic [fct_pkg::LINK_W-1:0] lk);
		if (e[0])
			pair_words[e >> 1][fct_pkg::WORD_W-1:fct_pkg::LINK_W] = lk;
		else
			pair_words[e >> 1][fct_pkg::LINK_W-1:0] = lk;
	endtask

	function automatic int scan_stop();
		int stop;
		stop = 2 + int'(scan_len);
		return (stop > fct_pkg::ENTRIES) ? fct_pkg::ENTRIES : stop;
	endfunction

	task automatic predict_op(
		input  logic [fct_pkg::FUNC_W-1:0] f,
		input  logic [fct_pkg::IDX_W-1:0]  idx,
		input  logic [fct_pkg::LINK_W-1:0] lv,
		input  logic [fct_pkg::OFF_W-1:0]  off,
		input  logic [fct_pkg::BYTE_W-1:0] bd,
		output outcome_t                   r
	);
		int p, lane, stop, hits, want;
		r = '0;
		r.status = fct_pkg::ST_OK;
		case (f)
			fct_pkg::F_READ, fct_pkg::F_STORE, fct_pkg::F_REMOVE: begin
				if (int'(idx) >= fct_pkg::ENTRIES) begin
					r.status = fct_pkg::ST_RANGE;
				end else begin
					if (f != fct_pkg::F_STORE)
						r.value = entry_link(int'(idx));
					if (f == fct_pkg::F_STORE)
						set_link(int'(idx), lv);
					else if (f == fct_pkg::F_REMOVE)
						set_link(int'(idx), '0);
				end
			end
			fct_pkg::F_FIRST, fct_pkg::F_SECOND: begin
				stop = scan_stop();
				want = (f == fct_pkg::F_FIRST) ? 1 : 2;
				hits = 0;
				r.status = fct_pkg::ST_NOFREE;
				for (int i = 2; i < stop; i++) begin
					if (entry_link(i) == '0) begin
						hits++;
						if (hits == want) begin
							r.value = fct_pkg::LINK_W'(i);
							r.status = fct_pkg::ST_OK;
							break;
						end
					end
				end
			end
			fct_pkg::F_COUNT: begin
				stop = scan_stop();
				for (int i = 2; i < stop; i++)
					if (entry_link(i) == '0)
						r.value++;
			end
			default: begin
				if (int'(off) >= fct_pkg::TABLE_BYTES) begin
					r.status = fct_pkg::ST_RANGE;
				end else begin
					p = int'(off) / 3;
					lane = int'(off) % 3;
					if (f == fct_pkg::F_WRBYTE)
						pair_words[p][fct_pkg::BYTE_W*lane +: fct_pkg::BYTE_W] = bd;
					else
						r.byte_out = pair_words[p][fct_pkg::BYTE_W*lane +: fct_pkg::BYTE_W];
				end
			end
		endcase
	endtask

	always @(posedge clk) begin
		outcome_t act, exp_r;
		if (arst_n) begin
			if (done) begin
				act = '{value, byte_out, status};
				if (pending_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: unexpected result value=%0d byte=%0d status=%0d",
							$realtime, value, byte_out, status);
				end else begin
					exp_r = pending_results.pop_front();
					if (act !== exp_r) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%0t: mismatch exp %0d/%0d/%0d act %0d/%0d/%0d",
								$realtime, exp_r.value, exp_r.byte_out, exp_r.status,
								act.value, act.byte_out, act.status);
					end
				end
			end
			if (cfg_wr_en)
				scan_len = cfg_wr_data;
			if (start && !busy) begin
				predict_op(func, entry_index, link_value, byte_offset, byte_data, exp_r);
				pending_results.push_back(exp_r);
			end
			outstanding = pending_results.size();
		end
	end

endmodule

// ----- bench/tb_fat12_cluster_table.sv -----
`timescale 1ns / 1ps

module tb_fat12_cluster_table;

	logic                       clk;
	logic                       arst_n;
	logic                       start;
	logic                       busy;
	logic [fct_pkg::FUNC_W-1:0] func;
	logic [fct_pkg::IDX_W-1:0]  entry_index;
	logic [fct_pkg::LINK_W-1:0] link_value;
	logic [fct_pkg::OFF_W-1:0]  byte_offset;
	logic [fct_pkg::BYTE_W-1:0] byte_data;
	logic                       cfg_wr_en;
	logic [fct_pkg::CNT_W-1:0]  cfg_wr_data;
	logic                       done;
	logic [fct_pkg::LINK_W-1:0] value;
	logic [fct_pkg::BYTE_W-1:0] byte_out;
	logic [fct_pkg::ST_W-1:0]   status;
	int                         fail_count;
	int                         outstanding;

	int idle_pct;
	int cur_len;
	int n_sent;
	int cfg_plan [8] = '{1023, 0, 1, 2, 37, 1022, 300, 5};

	fat12_cluster_table DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.func(func), .entry_index(entry_index), .link_value(link_value),
		.byte_offset(byte_offset), .byte_data(byte_data),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.done(done), .value(value), .byte_out(byte_out), .status(status)
	);

	fct_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.func(func), .entry_index(entry_index), .link_value(link_value),
		.byte_offset(byte_offset), .byte_data(byte_data),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.done(done), .value(value), .byte_out(byte_out), .status(status),
		.fail_count(fail_count), .outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic issue(
		input logic [fct_pkg::FUNC_W-1:0] f,
		input logic [fct_pkg::IDX_W-1:0]  idx,
		input logic [fct_pkg::LINK_W-1:0] lv,
		input logic [fct_pkg::OFF_W-1:0]  off,
		input logic [fct_pkg::BYTE_W-1:0] bd
	);
		idle_pct = (n_sent < 391) ? 33 : (n_sent < 782) ? 76 : 0;
		n_sent++;
		if (int'($urandom_range(99)) < idle_pct) begin
			start = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		start = 1'b1;
		func = f;
		entry_index = idx;
		link_value = lv;
		byte_offset = off;
		byte_data = bd;
		// hold until the transfer
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic settle();
		start = 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_len(input int n);
		cfg_wr_en = 1'b1;
		cfg_wr_data = fct_pkg::CNT_W'(n);
		cur_len = n;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	function automatic logic [fct_pkg::LINK_W-1:0] rand_link();
		return ($urandom_range(9) < 4) ? '0 : fct_pkg::LINK_W'($urandom_range(4095));
	endfunction

	task automatic issue_random();
		logic [fct_pkg::FUNC_W-1:0] f;
		logic [fct_pkg::IDX_W-1:0]  idx;
		logic [fct_pkg::OFF_W-1:0]  off;
		logic [fct_pkg::BYTE_W-1:0] bd;
		int                         hi;
		f = fct_pkg::FUNC_W'($urandom_range(fct_pkg::F_RDBYTE));
		hi = (cur_len + 3 > fct_pkg::ENTRIES - 1) ? fct_pkg::ENTRIES - 1 : cur_len + 3;
		idx = $urandom_range(1) ? fct_pkg::IDX_W'($urandom_range(fct_pkg::ENTRIES - 1))
			: fct_pkg::IDX_W'($urandom_range(hi));
		off = ($urandom_range(9) == 0)
			? fct_pkg::OFF_W'($urandom_range((1 << fct_pkg::OFF_W) - 1))
			: fct_pkg::OFF_W'($urandom_range(fct_pkg::TABLE_BYTES - 1));
		bd = ($urandom_range(9) < 3) ? '0 : fct_pkg::BYTE_W'($urandom_range(255));
		issue(f, idx, rand_link(), off, bd);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		func = fct_pkg::F_READ;
		entry_index = '0;
		link_value = '0;
		byte_offset = '0;
		byte_data = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		idle_pct = 0;
		cur_len = 0;
		n_sent = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		write_len(0);

		// load every entry so no scan touches an unwritten byte
		for (int e = 0; e < fct_pkg::ENTRIES; e++)
			issue(fct_pkg::F_STORE, fct_pkg::IDX_W'(e), rand_link(), '0, '0);
		settle();
		write_len(3);

		issue(fct_pkg::F_READ,   '0,       '0,      '0,       '0);
		issue(fct_pkg::F_STORE,  10'd1023, 12'hFFF, '0,       '0);
		issue(fct_pkg::F_READ,   10'd1023, '0,      '0,       '0);
		issue(fct_pkg::F_REMOVE, 10'd1023, '0,      '0,       '0);
		issue(fct_pkg::F_READ,   10'd1023, '0,      '0,       '0);
		issue(fct_pkg::F_STORE,  10'd2,    '0,      '0,       '0);
		issue(fct_pkg::F_STORE,  10'd3,    12'd5,   '0,       '0);
		issue(fct_pkg::F_STORE,  10'd4,    '0,      '0,       '0);
		issue(fct_pkg::F_FIRST,  '0,       '0,      '0,       '0);
		issue(fct_pkg::F_SECOND, '0,       '0,      '0,       '0);
		issue(fct_pkg::F_COUNT,  '0,       '0,      '0,       '0);
		issue(fct_pkg::F_STORE,  10'd4,    12'hFFF, '0,       '0);
		issue(fct_pkg::F_SECOND, '0,       '0,      '0,       '0);
		issue(fct_pkg::F_FIRST,  '0,       '0,      '0,       '0);
		issue(fct_pkg::F_WRBYTE, '0,       '0,      '0,       8'hFF);
		issue(fct_pkg::F_RDBYTE, '0,       '0,      '0,       '0);
		issue(fct_pkg::F_WRBYTE, '0,       '0,      11'd1535, 8'hA5);
		issue(fct_pkg::F_RDBYTE, '0,       '0,      11'd1535, '0);
		issue(fct_pkg::F_WRBYTE, '0,       '0,      11'd1536, 8'h12);
		issue(fct_pkg::F_RDBYTE, '0,       '0,      11'd2047, '0);
		issue(fct_pkg::F_RDBYTE, '0,       '0,      11'd4,    '0);
		issue(fct_pkg::F_READ,   10'd1,    '0,      '0,       '0);

		foreach (cfg_plan[k]) begin
			settle();
			write_len(cfg_plan[k]);
			for (int i = 0; i < 16; i++) begin
				if ($urandom_range(49) == 0)
					settle();
				issue_random();
			end
		end
		settle();
		repeat (20) @(negedge clk);

		if (fail_count == 0 && outstanding == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
